// ----- design/dgsp_pkg.sv -----
// shared constants, codes and control bundles for the dense graph shortest path block
package dgsp_pkg;

  localparam int NODE_COUNT_DEF  = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed field widths of the words on the ports
  localparam int ID_W   = 4;
  localparam int WIN_W  = 16;
  localparam int DIST_W = 20;

  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PASS,
    ST_DRAIN,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_FAIL
  } state_t;

  // sequencer to node scratch unit
  typedef struct packed {
    logic load;     // start of a round: take the chosen node
    logic first;    // first round: source is chosen, scratch reads as blank
    logic issue;    // read one scratch entry and one matrix entry
    logic walk_rd;  // read one scratch entry for the path walk
  } node_ctl_t;

  // sequencer to path buffer and output register
  typedef struct packed {
    logic push;       // store one walked node
    logic rd;         // read one stored node
    logic load_path;  // present a path node word
    logic load_fail;  // present the unreachable word
    logic last;       // final word of the query
  } path_ctl_t;

endpackage

// ----- design/dgsp_edge_ram.sv -----
// adjacency matrix memory with a clearing sweep after reset
module dgsp_edge_ram #(
  parameter int NODE_COUNT  = dgsp_pkg::NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF,
  localparam int NB = $clog2(NODE_COUNT),
  localparam int AW = 2 * NB
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [WEIGHT_BITS-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [WEIGHT_BITS-1:0] rd_data,
  output logic                   clearing
);

  localparam int DEPTH = 1 << AW;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]          clr_addr;

  // sweep every row and column back to no edge
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/dgsp_node_unit.sv -----
// per-node scratch memory with the combined relax and select pass
module dgsp_node_unit #(
  parameter int NODE_COUNT  = dgsp_pkg::NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF,
  localparam int NB = $clog2(NODE_COUNT),
  localparam int DB = WEIGHT_BITS + NB
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dgsp_pkg::node_ctl_t       ctl,
  input  logic [NB-1:0]             src,
  input  logic [NB-1:0]             pass_idx,
  input  logic [NB-1:0]             walk_addr,
  input  logic [WEIGHT_BITS-1:0]    edge_w,
  output logic [NB-1:0]             cur_u,
  output logic [DB-1:0]             rd_dist,
  output logic [NB-1:0]             rd_pred,
  output logic                      rd_hp
);

  typedef struct packed {
    logic [DB-1:0] cost;
    logic [NB-1:0] pred;
    logic          hp;
    logic          done;
  } entry_t;

  entry_t        mem [NODE_COUNT];
  entry_t        rdata;
  entry_t        cur;
  entry_t        upd_e;
  logic [NB-1:0] rd_addr;

  logic          s1_vld;
  logic [NB-1:0] s1_idx;
  logic          fresh;

  // node being settled this round
  logic [NB-1:0] u;
  logic [DB-1:0] ud;
  logic          relax_en;
  logic          mark_en;

  // choice for the following round
  logic          pick_found;
  logic [NB-1:0] pick_idx;
  logic [DB-1:0] pick_dist;
  logic          spare_found;
  logic [NB-1:0] spare_idx;

  logic [DB-1:0] cand;
  logic          v_src;
  logic          done1;
  logic          reached0;
  logic          reached1;
  logic          upd;
  logic          take;

  // relax one entry against the settled node and judge it for the next pick
  always_comb begin
    cur      = fresh ? '0 : rdata;
    v_src    = (s1_idx == src);
    done1    = cur.done | (mark_en & (s1_idx == u));
    reached0 = v_src | cur.hp;
    cand     = ud + DB'(edge_w);
    upd      = relax_en & ~done1 & (edge_w != '0) & (~reached0 | (cand < cur.cost));
    upd_e.cost = upd ? cand : cur.cost;
    upd_e.pred = upd ? u : cur.pred;
    upd_e.hp   = cur.hp | upd;
    upd_e.done = done1;
    reached1 = v_src | upd_e.hp;
    // ascending scan with <=, so the highest index wins a tie
    take     = ~done1 & reached1 & (~pick_found | (upd_e.cost <= pick_dist));
    rd_addr  = ctl.walk_rd ? walk_addr : pass_idx;
  end

  // scratch memory: write back the pass result, registered read
  always_ff @(posedge clk) begin
    if (s1_vld) begin
      mem[s1_idx] <= upd_e;
    end
    if (ctl.issue | ctl.walk_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  // round control and pick tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld      <= 1'b0;
      fresh       <= 1'b0;
      relax_en    <= 1'b0;
      mark_en     <= 1'b0;
      pick_found  <= 1'b0;
      spare_found <= 1'b0;
    end else begin
      s1_vld <= ctl.issue;
      if (ctl.load) begin
        fresh       <= ctl.first;
        pick_found  <= 1'b0;
        spare_found <= 1'b0;
        if (ctl.first) begin
          u        <= src;
          ud       <= '0;
          relax_en <= 1'b1;
          mark_en  <= 1'b1;
        end else if (pick_found) begin
          u        <= pick_idx;
          ud       <= pick_dist;
          relax_en <= 1'b1;
          mark_en  <= 1'b1;
        end else begin
          // nothing reached: retire the highest unvisited node only
          u        <= spare_idx;
          relax_en <= 1'b0;
          mark_en  <= spare_found;
        end
      end else if (s1_vld) begin
        if (~done1) begin
          spare_found <= 1'b1;
          spare_idx   <= s1_idx;
        end
        if (take) begin
          pick_found <= 1'b1;
          pick_idx   <= s1_idx;
          pick_dist  <= upd_e.cost;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      s1_idx <= pass_idx;
    end
  end

  assign cur_u   = u;
  assign rd_dist = rdata.cost;
  assign rd_pred = rdata.pred;
  assign rd_hp   = rdata.hp;

endmodule

// ----- design/dgsp_path_buf.sv -----
// walked path buffer and output word register with distance saturation
module dgsp_path_buf #(
  parameter int NODE_COUNT  = dgsp_pkg::NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF,
  localparam int NB = $clog2(NODE_COUNT),
  localparam int DB = WEIGHT_BITS + NB
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dgsp_pkg::path_ctl_t         ctl,
  input  logic [NB-1:0]               wr_addr,
  input  logic [NB-1:0]               wr_node,
  input  logic [NB-1:0]               rd_addr,
  input  logic [DB-1:0]               route_dist,
  input  logic [dgsp_pkg::ID_W-1:0]   fail_node,
  input  logic                        out_ready,
  output logic                        slot_free,
  output logic                        out_valid,
  output logic [dgsp_pkg::ID_W-1:0]   path_node,
  output logic [dgsp_pkg::DIST_W-1:0] total_distance,
  output logic                        unreachable,
  output logic                        last
);

  localparam int DXW = (DB > dgsp_pkg::DIST_W) ? DB : dgsp_pkg::DIST_W;

  logic [NB-1:0]               mem [NODE_COUNT];
  logic [NB-1:0]               rdata;
  logic [DXW-1:0]              dist_x;
  logic [dgsp_pkg::DIST_W-1:0] dist_sat;

  // clamp the path distance to the output field
  always_comb begin
    dist_x   = DXW'(route_dist);
    dist_sat = (dist_x > DXW'(dgsp_pkg::DIST_SAT)) ? dgsp_pkg::DIST_SAT
                                                   : dgsp_pkg::DIST_W'(dist_x);
  end

  assign slot_free = ~out_valid | out_ready;

  // path memory, destination first
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= wr_node;
    end
    if (ctl.rd) begin
      rdata <= mem[rd_addr];
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_path | ctl.load_fail) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (ctl.load_path) begin
      path_node      <= dgsp_pkg::ID_W'(rdata);
      total_distance <= dist_sat;
      unreachable    <= 1'b0;
      last           <= ctl.last;
    end else if (ctl.load_fail) begin
      path_node      <= fail_node;
      total_distance <= '0;
      unreachable    <= 1'b1;
      last           <= 1'b1;
    end
  end

endmodule

// ----- design/dense_graph_shortest_path.sv -----
// dense graph shortest path: top level with the query sequencer
//
//   channel | signals                                        | handshake
//   --------+------------------------------------------------+-----------------------
//   in      | operation, from_node, to_node, weight          | in_valid / in_ready
//   out     | path_node, total_distance, unreachable, last   | out_valid / out_ready
//
// an edge write is taken in the idle state. a query runs NODE_COUNT-1 rounds over
// the node scratch memory (one entry read, relaxed and written back per cycle),
// each round a load, a pass over every node and a drain, then walks the
// predecessors and emits the path nodes. after reset the matrix memory is swept
// to zero, one entry a cycle, with in_ready low. a stalled output only holds
// the emit step or the unreachable word of the query.
module dense_graph_shortest_path #(
  parameter int NODE_COUNT  = dgsp_pkg::NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [dgsp_pkg::ID_W-1:0]   from_node,
  input  logic [dgsp_pkg::ID_W-1:0]   to_node,
  input  logic [dgsp_pkg::WIN_W-1:0]  weight,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dgsp_pkg::ID_W-1:0]   path_node,
  output logic [dgsp_pkg::DIST_W-1:0] total_distance,
  output logic                        unreachable,
  output logic                        last
);

  localparam int NB = $clog2(NODE_COUNT);
  localparam int DB = WEIGHT_BITS + NB;
  localparam int LW = $clog2(NODE_COUNT + 1);
  localparam int AW = 2 * NB;

  dgsp_pkg::state_t    state;
  dgsp_pkg::state_t    state_next;
  dgsp_pkg::node_ctl_t nctl;
  dgsp_pkg::path_ctl_t pctl;

  logic [NB-1:0]             pass_idx;
  logic [NB-1:0]             round;
  logic [NB-1:0]             src;
  logic [NB-1:0]             walk_v;
  logic [LW-1:0]             len;
  logic [NB-1:0]             k;
  logic [dgsp_pkg::ID_W-1:0] fail_node;
  logic [DB-1:0]             path_dist;

  logic                   clearing;
  logic                   accept;
  logic                   is_query;
  logic                   in_range;
  logic                   idx_last;
  logic                   round_last;
  logic                   reach;
  logic                   stop;
  logic                   slot_free;

  logic                   edge_we;
  logic [AW-1:0]          edge_waddr;
  logic [WEIGHT_BITS-1:0] edge_wdata;
  logic                   edge_re;
  logic [AW-1:0]          edge_raddr;
  logic [WEIGHT_BITS-1:0] edge_w;

  logic [NB-1:0]          cur_u;
  logic [DB-1:0]          rd_dist;
  logic [NB-1:0]          rd_pred;
  logic                   rd_hp;

  // decode of the input word and loop conditions
  always_comb begin
    in_ready   = (state == dgsp_pkg::ST_IDLE) & ~clearing;
    accept     = in_valid & in_ready;
    is_query   = (operation == dgsp_pkg::OP_QUERY);
    in_range   = (int'(from_node) < NODE_COUNT) & (int'(to_node) < NODE_COUNT);
    idx_last   = (pass_idx == NB'(NODE_COUNT - 1));
    round_last = (round == NB'(NODE_COUNT - 2));
    reach      = (walk_v == src) | rd_hp;
    stop       = (walk_v == src) | ~rd_hp | (len == LW'(NODE_COUNT - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dgsp_pkg::ST_IDLE: begin
        if (accept & is_query) begin
          state_next = in_range ? dgsp_pkg::ST_LOAD : dgsp_pkg::ST_FAIL;
        end
      end
      dgsp_pkg::ST_LOAD:  state_next = dgsp_pkg::ST_PASS;
      dgsp_pkg::ST_PASS: begin
        if (idx_last) begin
          state_next = dgsp_pkg::ST_DRAIN;
        end
      end
      dgsp_pkg::ST_DRAIN: begin
        state_next = round_last ? dgsp_pkg::ST_WALK_RD : dgsp_pkg::ST_LOAD;
      end
      dgsp_pkg::ST_WALK_RD: state_next = dgsp_pkg::ST_WALK_CHK;
      dgsp_pkg::ST_WALK_CHK: begin
        if ((len == '0) & ~reach) begin
          state_next = dgsp_pkg::ST_FAIL;
        end else if (stop) begin
          state_next = dgsp_pkg::ST_EMIT_RD;
        end else begin
          state_next = dgsp_pkg::ST_WALK_RD;
        end
      end
      dgsp_pkg::ST_EMIT_RD: state_next = dgsp_pkg::ST_EMIT_LD;
      dgsp_pkg::ST_EMIT_LD: begin
        if (slot_free) begin
          state_next = (k == '0) ? dgsp_pkg::ST_IDLE : dgsp_pkg::ST_EMIT_RD;
        end
      end
      dgsp_pkg::ST_FAIL: begin
        if (slot_free) begin
          state_next = dgsp_pkg::ST_IDLE;
        end
      end
      default: state_next = dgsp_pkg::ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    nctl       = '0;
    pctl       = '0;
    nctl.first = (round == '0);
    pctl.last  = (k == '0);
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    edge_waddr = {NB'(from_node), NB'(to_node)};
    edge_wdata = WEIGHT_BITS'(weight);
    edge_raddr = {cur_u, pass_idx};
    unique case (state)
      dgsp_pkg::ST_IDLE:     edge_we = accept & ~is_query & in_range;
      dgsp_pkg::ST_LOAD:     nctl.load = 1'b1;
      dgsp_pkg::ST_PASS: begin
        nctl.issue = 1'b1;
        edge_re    = 1'b1;
      end
      dgsp_pkg::ST_DRAIN:    ;
      dgsp_pkg::ST_WALK_RD:  nctl.walk_rd = 1'b1;
      dgsp_pkg::ST_WALK_CHK: pctl.push = ~((len == '0) & ~reach);
      dgsp_pkg::ST_EMIT_RD:  pctl.rd = 1'b1;
      dgsp_pkg::ST_EMIT_LD:  pctl.load_path = slot_free;
      dgsp_pkg::ST_FAIL:     pctl.load_fail = slot_free;
      default:               ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // query counters and walk registers
  always_ff @(posedge clk) begin
    if (accept & is_query) begin
      src       <= NB'(from_node);
      walk_v    <= NB'(to_node);
      fail_node <= to_node;
      round     <= '0;
      pass_idx  <= '0;
      len       <= '0;
    end
    if (state == dgsp_pkg::ST_PASS) begin
      pass_idx <= idx_last ? '0 : pass_idx + 1'b1;
    end
    if (state == dgsp_pkg::ST_DRAIN) begin
      round <= round + 1'b1;
    end
    if (state == dgsp_pkg::ST_WALK_CHK) begin
      if (len == '0) begin
        path_dist <= rd_dist;
      end
      if (pctl.push) begin
        len    <= len + 1'b1;
        k      <= len[NB-1:0];
        walk_v <= rd_pred;
      end
    end
    if (pctl.load_path) begin
      k <= k - 1'b1;
    end
  end

  dgsp_edge_ram #(
    .NODE_COUNT  (NODE_COUNT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_edge_ram (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (edge_we),
    .wr_addr  (edge_waddr),
    .wr_data  (edge_wdata),
    .rd_en    (edge_re),
    .rd_addr  (edge_raddr),
    .rd_data  (edge_w),
    .clearing (clearing)
  );

  dgsp_node_unit #(
    .NODE_COUNT  (NODE_COUNT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_node_unit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (nctl),
    .src       (src),
    .pass_idx  (pass_idx),
    .walk_addr (walk_v),
    .edge_w    (edge_w),
    .cur_u     (cur_u),
    .rd_dist   (rd_dist),
    .rd_pred   (rd_pred),
    .rd_hp     (rd_hp)
  );

  dgsp_path_buf #(
    .NODE_COUNT  (NODE_COUNT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_path_buf (
    .clk            (clk),
    .rst            (rst),
    .ctl            (pctl),
    .wr_addr        (len[NB-1:0]),
    .wr_node        (walk_v),
    .rd_addr        (k),
    .route_dist     (path_dist),
    .fail_node      (fail_node),
    .out_ready      (out_ready),
    .slot_free      (slot_free),
    .out_valid      (out_valid),
    .path_node      (path_node),
    .total_distance (total_distance),
    .unreachable    (unreachable),
    .last           (last)
  );

endmodule

// ----- design/dgsp_checker.sv -----
// port-level checks for the dense graph shortest path block, bound to the top level
module dgsp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dgsp_pkg::ID_W-1:0]   path_node,
  input logic [dgsp_pkg::DIST_W-1:0] total_distance,
  input logic                        unreachable,
  input logic                        last
);

  // a waiting output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(path_node) &&
      $stable(total_distance) && $stable(unreachable) && $stable(last))
    else $error("output word changed while stalled");

  // unreachable word is single and carries no distance
  a_unr_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && unreachable |-> last && (total_distance == '0))
    else $error("unreachable word without last or with distance");

  // an edge write never makes a word
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == dgsp_pkg::OP_WRITE) && !out_valid
      |=> !out_valid)
    else $error("word appeared after an edge write");

  // a query keeps the input side busy for its search
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == dgsp_pkg::OP_QUERY) |=> !in_ready)
    else $error("input taken right after a query");

  // reset empties the output and starts the matrix sweep
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind dense_graph_shortest_path dgsp_checker u_checker (.*);
